// ===== sv/sbl_pkg.sv =====
// Shared types, register indexes and operation codes for the sprite pixel blend unit.
package sbl_pkg;

	localparam int NCH = 3;

	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_ADD    = 2'd1;
	localparam logic [1:0] MODE_SUB    = 2'd2;
	localparam logic [1:0] MODE_MUL    = 2'd3;

	localparam logic [1:0] KIND_OPAQUE = 2'd0;
	localparam logic [1:0] KIND_BINARY = 2'd1;
	localparam logic [1:0] KIND_FULL   = 2'd2;

	localparam logic [1:0] REG_BLEND_MODE = 2'd0;
	localparam logic [1:0] REG_ALPHA_KIND = 2'd1;
	localparam logic [1:0] REG_COLOR_MOD  = 2'd2;

	localparam logic [31:0] MOD_WHITE = 32'hffff_ffff;
	localparam logic [7:0]  CH_MAX    = 8'hff;

	localparam logic [2:0] OP_NORM  = 3'd0;
	localparam logic [2:0] OP_ADD   = 3'd1;
	localparam logic [2:0] OP_SUB   = 3'd2;
	localparam logic [2:0] OP_MUL   = 3'd3;
	localparam logic [2:0] OP_COPY  = 3'd4;
	localparam logic [2:0] OP_BCOPY = 3'd5;

	// alpha in the lowest byte, blue in the highest
	typedef struct packed {
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
		logic [7:0] a;
	} pix_t;

	// index 0 red, 1 green, 2 blue
	typedef logic [NCH-1:0][7:0] chan_t;

	typedef struct packed {
		logic [2:0]            op;
		logic                  ina_nz;
		logic                  sa_nz;
		logic [7:0]            ina;
		pix_t                  src;
		pix_t                  dst;
		logic [NCH-1:0][15:0]  sm;
		logic [NCH-1:0][15:0]  dsa;
		logic [NCH-1:0]        m255;
	} s1_t;

	typedef struct packed {
		logic [2:0]            op;
		logic                  ina_nz;
		logic                  sa_nz;
		pix_t                  src;
		pix_t                  dst;
		logic [NCH-1:0][31:0]  prod;
		logic [NCH-1:0][15:0]  dn;
	} s2_t;

	function automatic chan_t rgb(input pix_t p);
		rgb = {p.b, p.g, p.r};
	endfunction

endpackage

// ===== sv/sbl_front.sv =====
// First stage: operation decode, modulated alpha and the first per-channel products.
module sbl_front import sbl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  pix_t        src,
	input  pix_t        dst,
	input  logic [1:0]  mode,
	input  logic [1:0]  kind,
	input  logic [31:0] modulator,
	output logic        valid_s1,
	output s1_t         stage_s1
);

	chan_t       mc;
	chan_t       sc;
	chan_t       dc;
	logic [15:0] ina_full;
	logic        white;
	s1_t         nxt;

	assign mc       = {modulator[15:8], modulator[23:16], modulator[31:24]};
	assign sc       = rgb(src);
	assign dc       = rgb(dst);
	assign ina_full = src.a * modulator[7:0];
	assign white    = (modulator == MOD_WHITE);

	always_comb begin
		nxt        = '0;
		nxt.ina    = ina_full[15:8];
		nxt.ina_nz = (ina_full[15:8] != 8'd0);
		nxt.sa_nz  = (src.a != 8'd0);
		nxt.src    = src;
		nxt.dst    = dst;
		priority if (white && mode == MODE_NORMAL && kind == KIND_OPAQUE) begin
			nxt.op = OP_COPY;
		end else if (white && mode == MODE_NORMAL && kind == KIND_BINARY) begin
			nxt.op = OP_BCOPY;
		end else if (mode == MODE_ADD) begin
			nxt.op = OP_ADD;
		end else if (mode == MODE_SUB) begin
			nxt.op = OP_SUB;
		end else if (mode == MODE_MUL) begin
			nxt.op = OP_MUL;
		end else begin
			nxt.op = OP_NORM;
		end
		for (int i = 0; i < NCH; i++) begin
			nxt.sm[i]   = sc[i] * mc[i];
			nxt.dsa[i]  = dc[i] * src.a;
			nxt.m255[i] = (mc[i] == CH_MAX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_s1 <= nxt;
		end
	end

endmodule

// ===== sv/sbl_mult.sv =====
// Second stage: the wide per-channel product and the destination weight product.
module sbl_mult import sbl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid_s1,
	input  s1_t  stage_s1,
	output logic valid_s2,
	output s2_t  stage_s2
);

	chan_t                sc;
	chan_t                dc;
	logic [NCH-1:0][15:0] fa;
	logic [NCH-1:0][15:0] fb;
	logic [7:0]           inv_ina;
	s2_t                  nxt;

	assign sc      = rgb(stage_s1.src);
	assign dc      = rgb(stage_s1.dst);
	assign inv_ina = CH_MAX - stage_s1.ina;

	// outside normal mode, a modulator byte of 255 takes the unmodulated formula: s<<8 stands in for s*m
	always_comb begin
		nxt        = '0;
		nxt.op     = stage_s1.op;
		nxt.ina_nz = stage_s1.ina_nz;
		nxt.sa_nz  = stage_s1.sa_nz;
		nxt.src    = stage_s1.src;
		nxt.dst    = stage_s1.dst;
		for (int i = 0; i < NCH; i++) begin
			fa[i] = (stage_s1.op != OP_NORM && stage_s1.m255[i]) ? {sc[i], 8'h00}
				: stage_s1.sm[i];
			fb[i] = (stage_s1.op == OP_SUB) ? stage_s1.dsa[i] : {8'h00, stage_s1.ina};
			nxt.prod[i] = fa[i] * fb[i];
			nxt.dn[i]   = dc[i] * inv_ina;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_s2 <= nxt;
		end
	end

endmodule

// ===== sv/sbl_mix.sv =====
// Third stage: per-mode combine, saturation, gating and the result register.
module sbl_mix import sbl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid_s2,
	input  s2_t  stage_s2,
	output logic valid_s3,
	output pix_t out_s3
);

	chan_t                sc;
	chan_t                dc;
	chan_t                t;
	chan_t                res;
	logic [NCH-1:0][8:0]  sum;
	logic [NCH-1:0][15:0] dt;
	logic [7:0]           res_a;
	pix_t                 nxt;

	assign sc = rgb(stage_s2.src);
	assign dc = rgb(stage_s2.dst);

	always_comb begin
		for (int i = 0; i < NCH; i++) begin
			t[i]   = (stage_s2.op == OP_SUB) ? stage_s2.prod[i][31:24]
				: stage_s2.prod[i][23:16];
			sum[i] = {1'b0, dc[i]} + {1'b0, t[i]};
			dt[i]  = dc[i] * t[i];
			unique case (stage_s2.op)
				OP_COPY:  res[i] = sc[i];
				OP_BCOPY: res[i] = stage_s2.sa_nz ? sc[i] : dc[i];
				OP_ADD: begin
					if (!stage_s2.ina_nz) res[i] = dc[i];
					else if (sum[i][8]) res[i] = CH_MAX;
					else res[i] = sum[i][7:0];
				end
				OP_SUB:   res[i] = (t[i] > dc[i]) ? 8'd0 : dc[i] - t[i];
				OP_MUL:   res[i] = stage_s2.ina_nz ? dt[i][15:8] : dc[i];
				OP_NORM:  res[i] = stage_s2.ina_nz ? stage_s2.dn[i][15:8] + t[i] : dc[i];
				default:  res[i] = dc[i];
			endcase
		end
		unique case (stage_s2.op)
			OP_COPY:  res_a = CH_MAX;
			OP_BCOPY: res_a = stage_s2.sa_nz ? CH_MAX : stage_s2.dst.a;
			OP_SUB:   res_a = CH_MAX;
			OP_NORM:  res_a = stage_s2.ina_nz ? CH_MAX : stage_s2.dst.a;
			default:  res_a = stage_s2.dst.a;
		endcase
		nxt.a = res_a;
		nxt.r = res[0];
		nxt.g = res[1];
		nxt.b = res[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s3 <= nxt;
		end
	end

endmodule

// ===== sv/sprite_pixel_blend.sv =====
// Top level of the sprite pixel blend unit: configuration registers and three-stage pipeline.
//
//  channel   | direction | payload
//  s_axis    | in        | tdata 64b: src a,r,g,b then dst a,r,g,b (byte each, low first)
//  m_axis    | out       | tdata 32b: new a,r,g,b (byte each, low first)
//  cfg       | in        | cfg_we, cfg_index 2b, cfg_data 32b, write only
//
// One pixel per clock while the sink is ready; the result is registered in each stage.
// Stage one decodes and forms s*m, d*sa and the modulated alpha, stage two
// forms the wide product, stage three combines and saturates into the output.
// Each stage advances when it is empty or the next one advances, so bubbles
// close up under back-pressure and nothing is dropped or repeated.
// Reset clears valid bits and loads the default configuration.
module sprite_pixel_blend import sbl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // src_alpha, src_red, src_green, src_blue,
	                                   // dst_alpha, dst_red, dst_green, dst_blue
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // new_alpha, new_red, new_green, new_blue
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [1:0]  mode_q;
	logic [1:0]  kind_q;
	logic [31:0] mod_q;

	logic en1;
	logic en2;
	logic en3;
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	s1_t  stage_s1;
	s2_t  stage_s2;
	pix_t out_s3;
	pix_t src;
	pix_t dst;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			kind_q <= KIND_FULL;
			mod_q  <= MOD_WHITE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BLEND_MODE: mode_q <= cfg_data[1:0];
				REG_ALPHA_KIND: kind_q <= cfg_data[1:0];
				REG_COLOR_MOD:  mod_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance a stage when it is empty or its successor advances
	assign en3 = !valid_s3 || m_axis_tready;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;

	assign s_axis_tready = en1;
	assign src           = s_axis_tdata[31:0];
	assign dst           = s_axis_tdata[63:32];

	sbl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en1),
		.in_valid  (s_axis_tvalid),
		.src       (src),
		.dst       (dst),
		.mode      (mode_q),
		.kind      (kind_q),
		.modulator (mod_q),
		.valid_s1  (valid_s1),
		.stage_s1  (stage_s1)
	);

	sbl_mult u_mult (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en2),
		.valid_s1 (valid_s1),
		.stage_s1 (stage_s1),
		.valid_s2 (valid_s2),
		.stage_s2 (stage_s2)
	);

	sbl_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en3),
		.valid_s2 (valid_s2),
		.stage_s2 (stage_s2),
		.valid_s3 (valid_s3),
		.out_s3   (out_s3)
	);

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata  = out_s3;

endmodule

// ===== sv/sbl_check.sv =====
// Port-level checker for the sprite pixel blend unit and its bind.
module sbl_check (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	// a result waiting for the sink holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped or changed while stalled");

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("result valid during reset");

	// a free sink frees every stage back to the input
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while sink ready");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
		|=> m_axis_tvalid)
		else $error("request did not reach the output in three cycles");

endmodule

bind sprite_pixel_blend sbl_check u_check (.*);

// ===== dv/tb.sv =====
// Self-checking testbench for the sprite pixel blend unit: streamed pixel pairs, predicted blends.
module tb;
	import sbl_pkg::*;

	// cfg_index value past the last register; writes to it must be ignored
	localparam logic [1:0] REG_NONE = 2'd3;

	// source in the low word, destination in the high word
	typedef struct packed {
		pix_t dst;
		pix_t src;
	} pixel_pair_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;  // src_alpha, src_red, src_green, src_blue,
	                                 // dst_alpha, dst_red, dst_green, dst_blue
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;       // new_alpha, new_red, new_green, new_blue
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	pixel_pair_t pending_pairs[$];
	pix_t        due_pixels[$];
	pixel_pair_t tx_pair;
	bit          tx_busy = 1'b0;
	pix_t        rx_got, rx_want;
	int          tx_idle = 19;
	int          rx_idle = 72;
	bit          hold_req = 1'b0;
	bit          hold_ack = 1'b0;
	int          hold_left = 0;
	int          n_err = 0;

	// configuration as the block should hold it
	logic [1:0]  cur_mode = MODE_NORMAL;
	logic [1:0]  cur_kind = KIND_FULL;
	logic [31:0] cur_mod = MOD_WHITE;

	sprite_pixel_blend uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	function automatic pix_t blend_pixel(input pix_t s, input pix_t d, input logic [1:0] mode,
			input logic [1:0] kind, input logic [31:0] modv);
		logic [2:0][7:0] sc, dc, mc, rc;
		logic [31:0] s32, d32, m32, sa32, ina, t;
		pix_t r;
		int i;
		sc = {s.b, s.g, s.r};
		dc = {d.b, d.g, d.r};
		mc = {modv[15:8], modv[23:16], modv[31:24]};
		sa32 = 32'(s.a);
		ina = (sa32 * 32'(modv[7:0])) >> 8;
		r = d;
		rc = dc;
		if (modv == MOD_WHITE && mode == MODE_NORMAL && kind == KIND_OPAQUE) begin
			r.a = CH_MAX;
			rc = sc;
		end else if (modv == MOD_WHITE && mode == MODE_NORMAL && kind == KIND_BINARY) begin
			if (s.a != 8'd0) begin
				r.a = CH_MAX;
				rc = sc;
			end
		end else begin
			for (i = 0; i < 3; i++) begin
				s32 = 32'(sc[i]);
				d32 = 32'(dc[i]);
				m32 = 32'(mc[i]);
				if (mode == MODE_SUB) begin
					// not gated by the modulated alpha; the product fits in 32 bits
					r.a = CH_MAX;
					t = (mc[i] != CH_MAX) ? (s32 * m32 * d32 * sa32) >> 24
					                      : (s32 * d32 * sa32) >> 16;
					rc[i] = (t > d32) ? 8'd0 : 8'(d32 - t);
				end else if (ina != 32'd0) begin
					if (mode == MODE_ADD || mode == MODE_MUL) begin
						t = (mc[i] != CH_MAX) ? (s32 * m32 * ina) >> 16 : (s32 * ina) >> 8;
						t = (mode == MODE_ADD) ? d32 + t : (d32 * t) >> 8;
						rc[i] = (t > 32'(CH_MAX)) ? CH_MAX : 8'(t);
					end else begin
						r.a = CH_MAX;
						rc[i] = 8'(((d32 * (32'(CH_MAX) - ina)) >> 8) + ((s32 * ina * m32) >> 16));
					end
				end
			end
		end
		r.r = rc[0];
		r.g = rc[1];
		r.b = rc[2];
		return r;
	endfunction

	// lean on the extremes now and then
	function automatic logic [7:0] chan_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic pix_t rand_pix();
		return {chan_byte(), chan_byte(), chan_byte(), chan_byte()};
	endfunction

	function automatic logic [31:0] rand_mod();
		case ($urandom_range(4))
			0: return 32'h0;
			1: return MOD_WHITE;
			default: return {chan_byte(), chan_byte(), chan_byte(), chan_byte()};
		endcase
	endfunction

	task automatic check_byte(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_err++;
		end
	endtask

	// Driver: once the last pair has gone, offer the next pending pair, with random idle gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				due_pixels.push_back(blend_pixel(tx_pair.src, tx_pair.dst, cur_mode, cur_kind,
					cur_mod));
				tx_busy = 1'b0;
			end
			if (!tx_busy) begin
				if (pending_pairs.size() != 0 && $urandom_range(99) >= tx_idle) begin
					tx_pair = pending_pairs.pop_front();
					tx_busy = 1'b1;
					s_axis_tdata <= tx_pair;
					s_axis_tvalid <= 1'b1;
				end else
					s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: check each result against the oldest prediction, and drive tready
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				rx_got = m_axis_tdata;
				if (due_pixels.size() == 0) begin
					$error("unexpected result %h", rx_got);
					n_err++;
				end else begin
					rx_want = due_pixels.pop_front();
					check_byte("new_alpha", rx_want.a, rx_got.a);
					check_byte("new_red", rx_want.r, rx_got.r);
					check_byte("new_green", rx_want.g, rx_got.g);
					check_byte("new_blue", rx_want.b, rx_got.b);
				end
			end
			if (hold_req != hold_ack) begin
				hold_ack = hold_req;
				hold_left = 150;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else
				m_axis_tready <= ($urandom_range(99) >= rx_idle);
		end
	end

	// wait until no request is queued, offered or awaiting its result
	task automatic drain();
		while (pending_pairs.size() != 0 || tx_busy || due_pixels.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// call at a clock edge; the write lands on the next edge
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_BLEND_MODE: cur_mode = val[1:0];
			REG_ALPHA_KIND: cur_kind = val[1:0];
			REG_COLOR_MOD:  cur_mod = val;
			default: ;
		endcase
	endtask

	task automatic apply_config(input logic [31:0] mode_w, input logic [31:0] kind_w,
			input logic [31:0] mod_w);
		drain();
		write_reg(REG_BLEND_MODE, mode_w);
		write_reg(REG_ALPHA_KIND, kind_w);
		write_reg(REG_COLOR_MOD, mod_w);
		cfg_we <= 1'b0;
	endtask

	task automatic push_corners();
		pending_pairs.push_back({32'hffff_ffff, 32'h0000_0000});
		pending_pairs.push_back({32'h0000_0000, 32'hffff_ffff});
		pending_pairs.push_back({32'hffff_ffff, 32'hffff_ffff});
	endtask

	initial begin
		logic [1:0] mode, kind;
		int p, k;
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset configuration first, then each blend path
		pending_pairs.push_back({32'h4080_c0ff, 32'h7f10_2030});
		apply_config(32'(MODE_NORMAL), 32'(KIND_OPAQUE), MOD_WHITE);
		push_corners();
		apply_config(32'(MODE_NORMAL), 32'(KIND_BINARY), MOD_WHITE);
		push_corners();
		apply_config(32'(MODE_NORMAL), 32'(KIND_FULL), 32'h80c0_40ff);
		push_corners();
		apply_config(32'(MODE_ADD), 32'(KIND_FULL), 32'hff40_c0ff);
		push_corners();
		// upper bits must be masked off: subtractive
		apply_config(32'hffff_fffe, 32'(KIND_FULL), 32'h10ff_80ff);
		push_corners();
		apply_config(32'(MODE_MUL), 32'hffff_fffd, 32'hffa0_50c0);
		push_corners();
		// undefined alpha kind blends as full alpha
		apply_config(32'(MODE_NORMAL), 32'd3, MOD_WHITE);
		push_corners();
		// write past the last register: nothing may change
		drain();
		write_reg(REG_NONE, 32'h0);
		cfg_we <= 1'b0;
		push_corners();

		for (p = 0; p < 21; p++) begin
			if (p < 7) begin
				tx_idle = 19;
				rx_idle = 72;
			end else if (p < 14) begin
				tx_idle = 72;
				rx_idle = 19;
			end else begin
				tx_idle = 0;
				rx_idle = 0;
			end
			if (p % 5 == 0) begin
				// copy paths need a white modulator in normal mode
				mode = MODE_NORMAL;
				kind = ((p / 5) % 2 == 0) ? KIND_OPAQUE : KIND_BINARY;
				apply_config(($urandom & ~32'h3) | 32'(mode), ($urandom & ~32'h3) | 32'(kind),
					MOD_WHITE);
			end else begin
				mode = 2'($urandom_range(3));
				kind = 2'($urandom_range(3));
				apply_config(($urandom & ~32'h3) | 32'(mode), ($urandom & ~32'h3) | 32'(kind),
					rand_mod());
			end
			for (k = 0; k < 50; k++)
				pending_pairs.push_back({rand_pix(), rand_pix()});
			// stall the output long enough to back up the pipe
			if (p == 16) begin
				@(posedge clk);
				hold_req <= ~hold_req;
			end
		end

		drain();
		if (n_err == 0 && due_pixels.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	initial begin
		#3200000;
		$display("tb failed");
		$finish;
	end

endmodule
